// ===== sv/scs_pkg.sv =====
package scs_pkg;

   localparam int unsigned POLY_SIZE       = 256;
   localparam int unsigned NUM_WORDS       = 8;
   localparam int unsigned COEFFS_PER_WORD = 32;
   localparam int unsigned CODE_BITS       = 2;
   localparam int unsigned ROW_W           = COEFFS_PER_WORD * CODE_BITS;
   localparam int unsigned ROW_BITS        = $clog2(NUM_WORDS);
   localparam int unsigned LANE_BITS       = $clog2(COEFFS_PER_WORD);
   localparam int unsigned SLOT_BITS       = $clog2(POLY_SIZE);
   localparam int unsigned FILL_BITS       = SLOT_BITS + 1;
   localparam int unsigned SIGN_W          = 64;
   localparam int unsigned SIGN_BIT_BITS   = $clog2(SIGN_W);
   localparam int unsigned SIGN_BYTES      = SIGN_W / 8;
   localparam int unsigned SEEN_BITS       = $clog2(SIGN_BYTES) + 1;
   localparam int unsigned REQ_TDATA_W     = 8;
   localparam int unsigned RSP_TDATA_W     = 72;

   typedef logic [CODE_BITS-1:0] code_type;
   typedef logic [ROW_W-1:0]     row_type;

   localparam code_type CODE_ZERO  = 2'd0;
   localparam code_type CODE_PLUS  = 2'd1;
   localparam code_type CODE_MINUS = 2'd2;

   typedef struct packed {
      logic                 en;
      logic [ROW_BITS-1:0]  row;
      logic [LANE_BITS-1:0] lane;
      code_type             code;
   } mem_wr_type;

   typedef enum logic [1:0] {
      SRC_ZERO,
      SRC_B,
      SRC_I,
      SRC_FWD
   } src_type;

endpackage

// ===== sv/sparse_challenge_sampler_core.sv =====
// Sparse ternary challenge sampler. Bytes of the XOF stream enter on the req
// channel, one item per cycle; an item with req_tuser set starts a new
// challenge. The first eight bytes of a challenge form the sign word, and each
// later byte is a candidate position that is either rejected or swapped into the
// coefficient store by a two-stage path (input register, then the copy write).
// Every byte is accepted without a stall, except that once the final position of a
// challenge is filled the input stalls while the eight 64-bit coefficient words
// go out on the rsp channel. Each word is read from the row memories in READ
// and LOAD and presented in SEND, where it waits while rsp_tready is low.
module sparse_challenge_sampler_core
   import scs_pkg::*;
#(
   parameter int unsigned FIRST_FILL_INDEX = 196
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [REQ_TDATA_W-1:0] req_tdata,   // xof_byte
   input  logic                   req_tuser,   // first
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [RSP_TDATA_W-1:0] rsp_tdata,   // word_index, coeff_word, zero fill
   output logic                   rsp_tlast
);

   mem_wr_type           b_wr;
   mem_wr_type           i_wr;
   row_type              b_rd_data;
   row_type              i_rd_data;
   logic [ROW_BITS-1:0]  fill_rd_row;
   logic [ROW_BITS-1:0]  emit_rd_row;
   logic [ROW_BITS-1:0]  rd_row;
   logic [POLY_SIZE-1:0] valid_bits;
   logic                 emit_start;
   logic                 emit_done;
   logic                 hold;

   scs_fill #(
      .FIRST_FILL_INDEX(FIRST_FILL_INDEX)
   ) u_fill (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (req_tvalid),
      .in_ready   (req_tready),
      .in_byte    (req_tdata),
      .in_first   (req_tuser),
      .b_rd_data  (b_rd_data),
      .i_rd_data  (i_rd_data),
      .emit_done  (emit_done),
      .b_wr       (b_wr),
      .i_wr       (i_wr),
      .rd_row     (fill_rd_row),
      .valid_bits (valid_bits),
      .emit_start (emit_start),
      .hold       (hold)
   );

   assign rd_row = hold ? emit_rd_row : fill_rd_row;

   scs_row_mem u_b_mem (
      .clock   (clock),
      .wr      (b_wr),
      .rd_row  (rd_row),
      .rd_data (b_rd_data)
   );

   scs_row_mem u_i_mem (
      .clock   (clock),
      .wr      (i_wr),
      .rd_row  (rd_row),
      .rd_data (i_rd_data)
   );

   scs_emit #(
      .FIRST_FILL_INDEX(FIRST_FILL_INDEX)
   ) u_emit (
      .clock      (clock),
      .reset      (reset),
      .start      (emit_start),
      .valid_bits (valid_bits),
      .b_rd_data  (b_rd_data),
      .i_rd_data  (i_rd_data),
      .rd_row     (emit_rd_row),
      .done       (emit_done),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

// ===== sv/scs_row_mem.sv =====
module scs_row_mem
   import scs_pkg::*;
(
   input  logic                clock,
   input  mem_wr_type          wr,
   input  logic [ROW_BITS-1:0] rd_row,
   output row_type             rd_data
);

   row_type mem_ff [NUM_WORDS];
   row_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem_ff[wr.row][{wr.lane, 1'b0} +: CODE_BITS] <= wr.code;
      end
      rd_data_ff <= mem_ff[rd_row];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== sv/scs_fill.sv =====
module scs_fill
   import scs_pkg::*;
#(
   parameter int unsigned FIRST_FILL_INDEX = 196
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   output logic                 in_ready,
   input  logic [7:0]           in_byte,
   input  logic                 in_first,
   input  row_type              b_rd_data,
   input  row_type              i_rd_data,
   input  logic                 emit_done,
   output mem_wr_type           b_wr,
   output mem_wr_type           i_wr,
   output logic [ROW_BITS-1:0]  rd_row,
   output logic [POLY_SIZE-1:0] valid_bits,
   output logic                 emit_start,
   output logic                 hold
);

   localparam logic [FILL_BITS-1:0] FillStart = FILL_BITS'(FIRST_FILL_INDEX);
   localparam logic [FILL_BITS-1:0] FillLast  = FILL_BITS'(POLY_SIZE - 1);

   logic                     x_valid_ff, x_valid_in;
   logic [7:0]               x_byte_ff, x_byte_in;
   logic                     x_first_ff, x_first_in;
   logic                     hold_ff, hold_in;
   logic [SIGN_W-1:0]        sign_word_ff, sign_word_in;
   logic [SEEN_BITS-1:0]     seen_ff, seen_in;
   logic [FILL_BITS-1:0]     fill_ff, fill_in;
   logic [SIGN_BIT_BITS-1:0] sbi_ff, sbi_in;
   logic                     done_ff, done_in;
   logic [POLY_SIZE-1:0]     valid_ff, valid_in;
   logic                     s2_valid_ff, s2_valid_in;
   logic                     s2_final_ff, s2_final_in;
   logic [SLOT_BITS-1:0]     s2_slot_ff, s2_slot_in;
   logic [LANE_BITS-1:0]     s2_lane_ff, s2_lane_in;
   src_type                  s2_src_ff, s2_src_in;
   code_type                 iw_code_ff, iw_code_in;

   logic                     go;
   logic                     clr;
   logic                     is_sign;
   logic                     is_take;
   logic                     is_final;
   logic [2:0]               sign_lane;
   logic [FILL_BITS-1:0]     b_wide;
   code_type                 copy_code;

   always_comb begin
      go        = x_valid_ff && !hold_ff;
      in_ready  = !x_valid_ff || !hold_ff;
      clr       = go && x_first_ff;
      b_wide    = {1'b0, x_byte_ff};
      is_sign   = go && (x_first_ff || (!done_ff && !seen_ff[SEEN_BITS-1]));
      is_take   = go && !x_first_ff && !done_ff && seen_ff[SEEN_BITS-1]
                  && !fill_ff[FILL_BITS-1] && (b_wide <= fill_ff);
      is_final  = is_take && (fill_ff == FillLast);
      sign_lane = x_first_ff ? 3'd0 : seen_ff[2:0];

      x_valid_in = x_valid_ff;
      x_byte_in  = x_byte_ff;
      x_first_in = x_first_ff;
      if (go) begin
         x_valid_in = 1'b0;
      end
      if (in_valid && in_ready) begin
         x_valid_in = 1'b1;
         x_byte_in  = in_byte;
         x_first_in = in_first;
      end

      sign_word_in = clr ? '0 : sign_word_ff;
      seen_in      = clr ? '0 : seen_ff;
      fill_in      = clr ? FillStart : fill_ff;
      sbi_in       = clr ? '0 : sbi_ff;
      done_in      = clr ? 1'b0 : done_ff;
      valid_in     = clr ? '0 : valid_ff;
      if (is_sign) begin
         sign_word_in[{sign_lane, 3'b000} +: 8] = x_byte_ff;
         seen_in = {1'b0, sign_lane} + SEEN_BITS'(1);
      end
      if (is_take) begin
         fill_in = fill_ff + FILL_BITS'(1);
         sbi_in  = sbi_ff + SIGN_BIT_BITS'(1);
         valid_in[x_byte_ff] = 1'b1;
      end
      if (is_final) begin
         done_in = 1'b1;
      end

      hold_in = hold_ff;
      if (emit_done) begin
         hold_in = 1'b0;
      end
      if (is_final) begin
         hold_in = 1'b1;
      end

      b_wr.en   = is_take;
      b_wr.row  = x_byte_ff[SLOT_BITS-1 -: ROW_BITS];
      b_wr.lane = x_byte_ff[LANE_BITS-1:0];
      b_wr.code = sign_word_ff[sbi_ff] ? CODE_MINUS : CODE_PLUS;

      s2_valid_in = is_take;
      s2_final_in = is_final;
      s2_slot_in  = fill_ff[SLOT_BITS-1:0];
      s2_lane_in  = x_byte_ff[LANE_BITS-1:0];
      if (valid_ff[x_byte_ff]) begin
         s2_src_in = SRC_B;
      end else if ((b_wide >= FillStart) && (b_wide < fill_ff)) begin
         s2_src_in = (s2_valid_ff && (s2_slot_ff == x_byte_ff)) ? SRC_FWD : SRC_I;
      end else begin
         s2_src_in = SRC_ZERO;
      end

      case (s2_src_ff)
         SRC_B:   copy_code = b_rd_data[{s2_lane_ff, 1'b0} +: CODE_BITS];
         SRC_I:   copy_code = i_rd_data[{s2_lane_ff, 1'b0} +: CODE_BITS];
         SRC_FWD: copy_code = iw_code_ff;
         default: copy_code = CODE_ZERO;
      endcase

      i_wr.en    = s2_valid_ff;
      i_wr.row   = s2_slot_ff[SLOT_BITS-1 -: ROW_BITS];
      i_wr.lane  = s2_slot_ff[LANE_BITS-1:0];
      i_wr.code  = copy_code;
      iw_code_in = s2_valid_ff ? copy_code : iw_code_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         x_valid_ff   <= 1'b0;
         hold_ff      <= 1'b0;
         sign_word_ff <= '0;
         seen_ff      <= '0;
         fill_ff      <= FillStart;
         sbi_ff       <= '0;
         done_ff      <= 1'b0;
         valid_ff     <= '0;
         s2_valid_ff  <= 1'b0;
         s2_final_ff  <= 1'b0;
      end else begin
         x_valid_ff   <= x_valid_in;
         hold_ff      <= hold_in;
         sign_word_ff <= sign_word_in;
         seen_ff      <= seen_in;
         fill_ff      <= fill_in;
         sbi_ff       <= sbi_in;
         done_ff      <= done_in;
         valid_ff     <= valid_in;
         s2_valid_ff  <= s2_valid_in;
         s2_final_ff  <= s2_final_in;
      end
      x_byte_ff  <= x_byte_in;
      x_first_ff <= x_first_in;
      s2_slot_ff <= s2_slot_in;
      s2_lane_ff <= s2_lane_in;
      s2_src_ff  <= s2_src_in;
      iw_code_ff <= iw_code_in;
   end

   assign rd_row     = x_byte_ff[SLOT_BITS-1 -: ROW_BITS];
   assign valid_bits = valid_ff;
   assign emit_start = s2_final_ff;
   assign hold       = hold_ff;

endmodule

// ===== sv/scs_emit.sv =====
module scs_emit
   import scs_pkg::*;
#(
   parameter int unsigned FIRST_FILL_INDEX = 196
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   input  logic [POLY_SIZE-1:0]   valid_bits,
   input  row_type                b_rd_data,
   input  row_type                i_rd_data,
   output logic [ROW_BITS-1:0]    rd_row,
   output logic                   done,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [RSP_TDATA_W-1:0] rsp_tdata,
   output logic                   rsp_tlast
);

   localparam logic [SLOT_BITS-1:0] FirstSlot = SLOT_BITS'(FIRST_FILL_INDEX);
   localparam logic [ROW_BITS-1:0]  LastRow   = ROW_BITS'(NUM_WORDS - 1);

   typedef enum logic [1:0] {
      EMIT_IDLE,
      EMIT_READ,
      EMIT_LOAD,
      EMIT_SEND
   } state_type;

   state_type                  state_ff;
   logic [ROW_BITS-1:0]        row_ff;
   logic [COEFFS_PER_WORD-1:0] vrow_ff;
   row_type                    word_ff;
   row_type                    word_in;

   always_comb begin
      for (int j = 0; j < COEFFS_PER_WORD; j++) begin
         if (vrow_ff[j]) begin
            word_in[CODE_BITS*j +: CODE_BITS] = b_rd_data[CODE_BITS*j +: CODE_BITS];
         end else if ({row_ff, LANE_BITS'(j)} >= FirstSlot) begin
            word_in[CODE_BITS*j +: CODE_BITS] = i_rd_data[CODE_BITS*j +: CODE_BITS];
         end else begin
            word_in[CODE_BITS*j +: CODE_BITS] = CODE_ZERO;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= EMIT_IDLE;
         row_ff   <= '0;
      end else begin
         case (state_ff)
            EMIT_IDLE: begin
               if (start) begin
                  state_ff <= EMIT_READ;
                  row_ff   <= '0;
               end
            end
            EMIT_READ: begin
               vrow_ff  <= valid_bits[{row_ff, LANE_BITS'(0)} +: COEFFS_PER_WORD];
               state_ff <= EMIT_LOAD;
            end
            EMIT_LOAD: begin
               word_ff  <= word_in;
               state_ff <= EMIT_SEND;
            end
            EMIT_SEND: begin
               if (rsp_tready) begin
                  if (row_ff == LastRow) begin
                     state_ff <= EMIT_IDLE;
                  end else begin
                     row_ff   <= row_ff + ROW_BITS'(1);
                     state_ff <= EMIT_READ;
                  end
               end
            end
            default: begin
               state_ff <= EMIT_IDLE;
            end
         endcase
      end
   end

   assign rd_row     = row_ff;
   assign rsp_tvalid = (state_ff == EMIT_SEND);
   assign rsp_tlast  = (row_ff == LastRow);
   assign done       = rsp_tvalid && rsp_tready && rsp_tlast;
   assign rsp_tdata  = {(RSP_TDATA_W - ROW_W - ROW_BITS)'(0), word_ff, row_ff};

endmodule

// ===== tb/sparse_challenge_sampler_core_tb.sv =====
module sparse_challenge_sampler_core_tb;
   import scs_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned FILL_START  = 196;
   localparam int          LONG_HOLD   = 300;
   localparam int          IDLE_LIMIT  = 3000;
   localparam int          DRAIN_WAIT  = 60;
   localparam int          CALM_NEEDED = 8;

   typedef struct {
      logic [7:0] xof_byte;
      logic       first;
      bit         hold;
   } xof_item_type;

   typedef struct {
      logic [ROW_BITS-1:0] word_index;
      row_type             coeff_word;
      logic                last_word;
   } coeff_word_type;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata = '0;   // xof_byte
   logic                   req_tuser = 1'b0; // first
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_TDATA_W-1:0] rsp_tdata;        // word_index, coeff_word, zero fill
   logic                   rsp_tlast;

   xof_item_type   xof_stream[$];
   coeff_word_type coeff_words_due[$];
   int             error_count = 0;

   code_type    ch_coeff[POLY_SIZE];
   logic [63:0] ch_sign;
   int          ch_sign_seen;
   int          ch_fill;
   int          ch_sign_bit;
   bit          ch_done;

   int burst_left;
   int gap_left;
   int calm_cycles;
   int words_taken = 0;
   int hold_left = 0;
   bit long_hold_done = 1'b0;
   int stall_mode = 0;
   int mode_left = 0;
   int idle_cycles = 0;

   sparse_challenge_sampler_core #(
      .FIRST_FILL_INDEX(FILL_START)
   ) dut (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata (req_tdata),
      .req_tuser (req_tuser),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata),
      .rsp_tlast (rsp_tlast)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   task automatic flag_mismatch(input string what);
      $display("MISMATCH at %0t: %s", $realtime, what);
      error_count++;
   endtask

   task automatic clear_challenge();
      for (int s = 0; s < POLY_SIZE; s++) ch_coeff[s] = CODE_ZERO;
      ch_sign      = '0;
      ch_sign_seen = 0;
      ch_fill      = FILL_START;
      ch_sign_bit  = 0;
      ch_done      = 1'b0;
   endtask

   task automatic absorb_byte(input logic [7:0] b, input logic first);
      coeff_word_type w;
      if (first) clear_challenge();
      else if (ch_done) return;
      if (ch_sign_seen < SIGN_BYTES) begin
         ch_sign[8*ch_sign_seen +: 8] = b;
         ch_sign_seen++;
         return;
      end
      if (ch_fill >= POLY_SIZE || int'(b) > ch_fill) return;
      ch_coeff[ch_fill] = ch_coeff[b];
      ch_coeff[b] = ch_sign[ch_sign_bit] ? CODE_MINUS : CODE_PLUS;
      ch_sign_bit = (ch_sign_bit + 1) % SIGN_W;
      ch_fill++;
      if (ch_fill < POLY_SIZE) return;
      ch_done = 1'b1;
      for (int k = 0; k < NUM_WORDS; k++) begin
         w.word_index = k[ROW_BITS-1:0];
         w.last_word  = (k == NUM_WORDS - 1);
         w.coeff_word = '0;
         for (int j = 0; j < COEFFS_PER_WORD; j++)
            w.coeff_word[CODE_BITS*j +: CODE_BITS] = ch_coeff[k*COEFFS_PER_WORD + j];
         coeff_words_due.push_back(w);
      end
   endtask

   task automatic push_byte(input logic [7:0] b, input logic first, input bit hold);
      xof_item_type it;
      it.xof_byte = b;
      it.first    = first;
      it.hold     = hold;
      xof_stream.push_back(it);
   endtask

   function automatic logic [7:0] sign_byte();
      case ($urandom % 4)
         0: return 8'h00;
         1: return 8'hFF;
         default: return 8'($urandom);
      endcase
   endfunction

   // Driver: bursts of items with random gaps; a held item waits for the block to drain.
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         req_tdata  <= '0;
         req_tuser  <= 1'b0;
         burst_left = 0;
         gap_left   = 0;
         calm_cycles = 0;
      end else begin
         calm_cycles = (coeff_words_due.size() == 0 && !(req_tvalid && req_tready)) ?
                       calm_cycles + 1 : 0;
         if (req_tvalid && req_tready) void'(xof_stream.pop_front());
         if (!req_tvalid || req_tready) begin
            if (gap_left > 0) begin
               gap_left--;
               req_tvalid <= 1'b0;
            end else if (xof_stream.size() != 0 &&
                         (!xof_stream[0].hold || calm_cycles >= CALM_NEEDED)) begin
               req_tvalid <= 1'b1;
               req_tdata  <= xof_stream[0].xof_byte;
               req_tuser  <= xof_stream[0].first;
               burst_left--;
               if (burst_left <= 0) begin
                  burst_left = $urandom_range(1, 40);
                  gap_left   = ($urandom % 3 == 0) ? 0 : $urandom_range(1, 8);
               end
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // Receiver: stall pattern that changes mode now and then, plus one long hold-off.
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) words_taken++;
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else if (!long_hold_done && rsp_tvalid && words_taken >= 2 * NUM_WORDS) begin
            long_hold_done = 1'b1;
            hold_left = LONG_HOLD;
            rsp_tready <= 1'b0;
         end else begin
            if (mode_left <= 0) begin
               stall_mode = $urandom % 3;
               mode_left  = $urandom_range(20, 120);
            end
            mode_left--;
            case (stall_mode)
               0: rsp_tready <= 1'b1;
               1: rsp_tready <= $urandom % 2;
               default: rsp_tready <= ($urandom % 8) != 0;
            endcase
         end
      end
   end

   always @(posedge clock) begin
      coeff_word_type want;
      if (reset) begin
         clear_challenge();
      end else begin
         if (req_tvalid && req_tready) absorb_byte(req_tdata, req_tuser);
         if (rsp_tvalid && rsp_tready) begin
            if (coeff_words_due.size() == 0) begin
               flag_mismatch($sformatf("unexpected item %h", rsp_tdata));
            end else begin
               want = coeff_words_due.pop_front();
               if (rsp_tdata[ROW_BITS-1:0] !== want.word_index)
                  flag_mismatch($sformatf("word_index %0d, expected %0d",
                                          rsp_tdata[ROW_BITS-1:0], want.word_index));
               if (rsp_tdata[ROW_BITS +: ROW_W] !== want.coeff_word)
                  flag_mismatch($sformatf("word %0d coeff_word %h, expected %h",
                                          want.word_index, rsp_tdata[ROW_BITS +: ROW_W],
                                          want.coeff_word));
               if (rsp_tlast !== want.last_word)
                  flag_mismatch($sformatf("word %0d last_word %b, expected %b",
                                          want.word_index, rsp_tlast, want.last_word));
               if (rsp_tdata[RSP_TDATA_W-1:ROW_BITS+ROW_W] !== '0)
                  flag_mismatch($sformatf("word %0d fill bits %b", want.word_index,
                                          rsp_tdata[RSP_TDATA_W-1:ROW_BITS+ROW_W]));
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
         end
      end
   end

   initial begin : stimulus
      int fill;
      int made;
      int completed;
      int n;
      bit hold;

      // Bytes straight after reset, with no first flag, start a challenge too.
      push_byte(8'hFF, 1'b0, 1'b0);
      push_byte(8'h00, 1'b0, 1'b0);
      push_byte(8'h80, 1'b0, 1'b0);
      push_byte(8'h01, 1'b0, 1'b0);
      push_byte(8'hFF, 1'b0, 1'b0);
      push_byte(8'h00, 1'b0, 1'b0);
      push_byte(8'h7F, 1'b0, 1'b0);
      push_byte(8'hFE, 1'b0, 1'b0);
      push_byte(8'hFF, 1'b0, 1'b0);
      push_byte(8'd197, 1'b0, 1'b0);
      push_byte(8'd196, 1'b0, 1'b0);
      push_byte(8'h00, 1'b0, 1'b0);
      push_byte(8'd196, 1'b0, 1'b0);
      push_byte(8'd199, 1'b0, 1'b0);
      // A restart in the middle of the sign bytes, then again with all ones.
      push_byte(8'h00, 1'b1, 1'b0);
      push_byte(8'h55, 1'b0, 1'b0);
      push_byte(8'hFF, 1'b1, 1'b0);
      for (int s = 1; s < SIGN_BYTES; s++) push_byte(8'hFF, 1'b0, 1'b0);
      push_byte(8'hFF, 1'b0, 1'b0);
      push_byte(8'h00, 1'b0, 1'b0);

      made = 0;
      completed = 0;
      while (made < 280 || completed < 3) begin
         if ($urandom % 7 != 0) begin
            hold = (completed == 1) || ($urandom % 5 == 0);
            push_byte(sign_byte(), 1'b1, hold);
            for (int s = 1; s < SIGN_BYTES; s++) push_byte(sign_byte(), 1'b0, 1'b0);
            made += SIGN_BYTES;
            fill = FILL_START;
            while (fill < POLY_SIZE) begin
               if (fill < POLY_SIZE - 1 && $urandom % 5 == 0) begin
                  push_byte(8'($urandom_range(fill + 1, POLY_SIZE - 1)), 1'b0, 1'b0);
               end else begin
                  case ($urandom % 6)
                     0: push_byte(8'($urandom_range(0, 3)), 1'b0, 1'b0);
                     1: push_byte(8'(fill), 1'b0, 1'b0);
                     default: push_byte(8'($urandom_range(0, fill)), 1'b0, 1'b0);
                  endcase
                  fill++;
               end
               made++;
            end
            completed++;
            // Trailing bytes after a finished challenge are ignored by the block.
            n = $urandom_range(0, 3);
            for (int s = 0; s < n; s++) push_byte(8'($urandom), 1'b0, 1'b0);
         end else begin
            push_byte(8'($urandom), 1'b1, 1'b0);
            n = $urandom_range(0, 40);
            for (int s = 0; s < n; s++)
               push_byte(8'($urandom), ($urandom % 16) == 0, 1'b0);
            made += n + 1;
         end
      end

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      while (xof_stream.size() != 0) @(posedge clock);
      while (coeff_words_due.size() != 0) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);
      if (coeff_words_due.size() != 0)
         flag_mismatch($sformatf("%0d words never arrived", coeff_words_due.size()));
      if (error_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
